// File: design/svf_pkg.sv
`default_nettype none

package svf_pkg;

  // Default sample width and fixed coefficient width
  localparam int SVF_SAMPLE_BITS = 16;
  localparam int SVF_COEF_BITS   = 16;

  // Microprogram: five steps, three-bit step counter
  localparam int SVF_PC_W = 3;

  // Multiplier coefficient operand
  typedef enum logic [1:0] {
    A_IN_TUNE,
    A_TUNE,
    A_DAMP
  } svf_asel_t;

  // Multiplier signal operand
  typedef enum logic [1:0] {
    B_BP,
    B_DIFF,
    B_HP
  } svf_bsel_t;

  // Jump conditions: hold on the current step while the condition stands
  typedef enum logic [1:0] {
    JC_NONE,
    JC_WAIT_IN,
    JC_WAIT_OUT
  } svf_jcond_t;

  // One control word of the program
  typedef struct packed {
    svf_asel_t  a_sel;
    svf_bsel_t  b_sel;
    logic       mul_en;
    logic       lp_tmp_en;
    logic       hp_en;
    logic       lp_en;
    logic       bp_en;
    svf_jcond_t jc;
    logic       last;
  } svf_uword_t;

  // Control from the sequencer to the datapath, enables already qualified
  typedef struct packed {
    svf_asel_t a_sel;
    svf_bsel_t b_sel;
    logic      mul_en;
    logic      lp_tmp_en;
    logic      hp_en;
    logic      lp_en;
    logic      bp_en;
    logic      in_ready;
  } svf_ctrl_t;

  // Status from the channels back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } svf_stat_t;

  // Program ROM
  //   0: wait for an item, product = tune * bp
  //   1: lowpass update into temp, product = damp * (x - bp)
  //   2: highpass from product and old lowpass, commit lowpass
  //   3: product = tune * hp
  //   4: bandpass update and result load, wait for a free output register
  function automatic svf_uword_t svf_ucode(input logic [SVF_PC_W-1:0] pc);
    svf_uword_t w;
    w.a_sel     = A_IN_TUNE;
    w.b_sel     = B_BP;
    w.mul_en    = 1'b0;
    w.lp_tmp_en = 1'b0;
    w.hp_en     = 1'b0;
    w.lp_en     = 1'b0;
    w.bp_en     = 1'b0;
    w.jc        = JC_NONE;
    w.last      = 1'b0;
    case (pc)
      3'd0: begin
        w.a_sel  = A_IN_TUNE;
        w.b_sel  = B_BP;
        w.mul_en = 1'b1;
        w.jc     = JC_WAIT_IN;
      end
      3'd1: begin
        w.a_sel     = A_DAMP;
        w.b_sel     = B_DIFF;
        w.mul_en    = 1'b1;
        w.lp_tmp_en = 1'b1;
      end
      3'd2: begin
        w.hp_en = 1'b1;
        w.lp_en = 1'b1;
      end
      3'd3: begin
        w.a_sel  = A_TUNE;
        w.b_sel  = B_HP;
        w.mul_en = 1'b1;
      end
      3'd4: begin
        w.bp_en = 1'b1;
        w.jc    = JC_WAIT_OUT;
        w.last  = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/svf_if.sv
`default_nettype none

// Input channel: one sample with its coefficients per item
interface svf_in_if
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = SVF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [SVF_COEF_BITS-1:0]      tune_coef;
  logic [SVF_COEF_BITS-1:0]      damping_gain;

  modport source (output valid, sample_in, tune_coef, damping_gain, input ready);
  modport sink   (input valid, sample_in, tune_coef, damping_gain, output ready);
endinterface

// Result channel: highpass, bandpass and lowpass per item
interface svf_out_if
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = SVF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] highpass_out;
  logic signed [SAMPLE_BITS-1:0] bandpass_out;
  logic signed [SAMPLE_BITS-1:0] lowpass_out;

  modport source (output valid, highpass_out, bandpass_out, lowpass_out, input ready);
  modport sink   (input valid, highpass_out, bandpass_out, lowpass_out, output ready);
endinterface

`default_nettype wire

// File: design/state_variable_filter_core.sv
`default_nettype none

// Two-integrator state variable filter, one audio sample per item.
// in_ch carries a signed sample, an unsigned Q1.15 tuning coefficient and an
// unsigned Q2.14 damping gain; out_ch returns the saturated highpass and the
// updated bandpass and lowpass integrators, one result item per input item.
// Both channels are valid/ready; an item moves when both are high.
// A five-step microprogram drives one shared 17 x (SAMPLE_BITS+4) multiplier,
// used three times per item. The item is taken in the first step, and the
// result is loaded into the output register on the last step, which holds
// while the output register is still full. A new item is taken only once
// the program has returned to its first step.
// in_ch.ready is high only while the program waits on its first step.
// The output register frees the input side: a new item is taken while a
// result still waits, and only its last step holds until the receiver takes
// the earlier result. Nothing is dropped under stalls.
// Reset clears both integrators, the step counter and the output valid.
module state_variable_filter_core
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = SVF_SAMPLE_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  svf_in_if.sink   in_ch,
  svf_out_if.source out_ch
);

  localparam int SW = SAMPLE_BITS;
  localparam int HW = SW + 4;
  localparam int AW = SVF_COEF_BITS + 1;
  localparam int PW = AW + HW;

  localparam logic signed [PW-1:0] ONE     = 1;
  localparam logic signed [PW-1:0] SAT_HI  = (ONE <<< (SW - 1)) - ONE;
  localparam logic signed [PW-1:0] SAT_LO  = -SAT_HI - ONE;
  localparam logic signed [PW-1:0] HALF_15 = ONE <<< 14;
  localparam logic signed [PW-1:0] HALF_14 = ONE <<< 13;

  svf_ctrl_t ctrl;
  svf_stat_t stat;

  logic signed [SW-1:0]      bp_r, lp_r, lp_tmp_r;
  logic [SVF_COEF_BITS-1:0]  fc_r, q_r;
  logic signed [SW:0]        diff_r;
  logic signed [HW-1:0]      hp_r;
  logic signed [PW-1:0]      prod_r;
  logic                      out_valid_r;
  logic signed [SW-1:0]      out_hp_r, out_bp_r, out_lp_r;

  logic                      accept;
  logic signed [AW-1:0]      mul_a;
  logic signed [HW-1:0]      mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [PW-1:0]      lp_w, bp_w, hp_w, rnd15_w, hpx_w, hp_full_w;
  logic signed [SW-1:0]      bp_new;

  function automatic logic signed [SW-1:0] sat_s(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[SW-1:0];
  endfunction

  // Sequencer
  assign stat.in_valid = in_ch.valid;
  assign stat.out_busy = out_valid_r && !out_ch.ready;

  svf_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  // No item is taken while reset is held
  assign in_ch.ready = ctrl.in_ready && rst_n;
  assign accept      = in_ch.valid && in_ch.ready;

  // Shared multiplier operands
  always_comb begin
    case (ctrl.a_sel)
      A_IN_TUNE: mul_a = $signed({1'b0, in_ch.tune_coef});
      A_TUNE:    mul_a = $signed({1'b0, fc_r});
      A_DAMP:    mul_a = $signed({1'b0, q_r});
      default:   mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_BP:    mul_b = $signed({{(HW - SW){bp_r[SW-1]}}, bp_r});
      B_DIFF:  mul_b = $signed({{(HW - SW - 1){diff_r[SW]}}, diff_r});
      B_HP:    mul_b = hp_r;
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Widened state and rounding arithmetic
  assign lp_w      = $signed({{(PW - SW){lp_r[SW-1]}}, lp_r});
  assign bp_w      = $signed({{(PW - SW){bp_r[SW-1]}}, bp_r});
  assign hp_w      = $signed({{(PW - HW){hp_r[HW-1]}}, hp_r});
  assign rnd15_w   = (prod_r + HALF_15) >>> 15;
  assign hpx_w     = prod_r - (lp_w <<< 14);
  assign hp_full_w = (hpx_w + HALF_14) >>> 14;
  assign bp_new    = sat_s(bp_w + rnd15_w);

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      fc_r   <= in_ch.tune_coef;
      q_r    <= in_ch.damping_gain;
      diff_r <= {in_ch.sample_in[SW-1], in_ch.sample_in} - {bp_r[SW-1], bp_r};
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_p;
    end
    if (ctrl.lp_tmp_en) begin
      lp_tmp_r <= sat_s(lp_w + rnd15_w);
    end
    if (ctrl.hp_en) begin
      hp_r <= hp_full_w[HW-1:0];
    end
  end

  // Integrators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
      bp_r <= '0;
    end else begin
      if (ctrl.lp_en) begin
        lp_r <= lp_tmp_r;
      end
      if (ctrl.bp_en) begin
        bp_r <= bp_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.bp_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bp_en) begin
      out_hp_r <= sat_s(hp_w);
      out_bp_r <= bp_new;
      out_lp_r <= lp_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.highpass_out = out_hp_r;
  assign out_ch.bandpass_out = out_bp_r;
  assign out_ch.lowpass_out  = out_lp_r;

  // Checks
  a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready right after an item was taken");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctrl.bp_en))
    else $error("result valid without a completed program");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.bp_en |-> !(out_valid_r && !out_ch.ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// File: design/svf_seq.sv
`default_nettype none

module svf_seq
  import svf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire svf_stat_t stat,
  output svf_ctrl_t      ctrl
);

  logic [SVF_PC_W-1:0] pc_r, pc_nxt;
  svf_uword_t          uw;
  logic                hold;

  assign uw = svf_ucode(pc_r);

  // Conditional jump to self
  always_comb begin
    case (uw.jc)
      JC_NONE:     hold = 1'b0;
      JC_WAIT_IN:  hold = !stat.in_valid;
      JC_WAIT_OUT: hold = stat.out_busy;
      default:     hold = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (uw.last) begin
      pc_nxt = '0;
    end else begin
      pc_nxt = pc_r + SVF_PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Enables fire only on a step that moves on
  always_comb begin
    ctrl.a_sel     = uw.a_sel;
    ctrl.b_sel     = uw.b_sel;
    ctrl.mul_en    = uw.mul_en    & !hold;
    ctrl.lp_tmp_en = uw.lp_tmp_en & !hold;
    ctrl.hp_en     = uw.hp_en     & !hold;
    ctrl.lp_en     = uw.lp_en     & !hold;
    ctrl.bp_en     = uw.bp_en     & !hold;
    ctrl.in_ready  = (uw.jc == JC_WAIT_IN);
  end

endmodule

`default_nettype wire
